// File: sv/dla_pkg.sv
package dla_pkg;

  // Lease table size
  localparam int unsigned LeaseEntries = 8;
  localparam int unsigned LeaseIdxW    = (LeaseEntries > 1) ? $clog2(LeaseEntries) : 1;

  // FNV-1a constants
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  // Message types
  localparam logic [7:0] MsgDiscover = 8'd1;
  localparam logic [7:0] MsgRequest  = 8'd3;

  // Reply kinds
  localparam logic [1:0] RkNone  = 2'd0;
  localparam logic [1:0] RkOffer = 2'd1;
  localparam logic [1:0] RkAck   = 2'd2;
  localparam logic [1:0] RkNak   = 2'd3;

  // NAK reasons
  localparam logic [2:0] NrNone      = 3'd0;
  localparam logic [2:0] NrExhausted = 3'd1;
  localparam logic [2:0] NrSubnet    = 3'd2;
  localparam logic [2:0] NrOutside   = 3'd3;
  localparam logic [2:0] NrInUse     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] RegServerAddr = 2'd0;
  localparam logic [1:0] RegSubnetMask = 2'd1;
  localparam logic [1:0] RegPoolStart  = 2'd2;
  localparam logic [1:0] RegPoolLength = 2'd3;

  typedef struct packed {
    logic [7:0]  req_type;
    logic [47:0] client_mac;
    logic        req_addr_valid;
    logic [31:0] req_addr;
    logic [31:0] client_cur_addr;
    logic        server_id_valid;
    logic [31:0] server_id;
  } dla_in_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [31:0] assigned_addr;
    logic [2:0]  nak_reason;
  } dla_out_t;

  // Lease table lookup results
  typedef struct packed {
    logic                 own_hit;
    logic [LeaseIdxW-1:0] own_idx;
    logic [31:0]          own_addr;
    logic                 addr_hit;
    logic [LeaseIdxW-1:0] addr_idx;
    logic                 free_any;
    logic [LeaseIdxW-1:0] free_idx;
  } dla_look_t;

endpackage

// File: sv/dla_lease_table.sv
module dla_lease_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [47:0]                   mac_i,
  input  logic [31:0]                   addr_i,
  input  logic                          we_i,
  input  logic [dla_pkg::LeaseIdxW-1:0] widx_i,
  input  logic [31:0]                   waddr_i,
  output dla_pkg::dla_look_t            look_o
);
  import dla_pkg::*;

  logic [LeaseEntries-1:0] valid_q;
  logic [47:0]             mac_q  [LeaseEntries];
  logic [31:0]             addr_q [LeaseEntries];

  // Hold valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[widx_i] <= 1'b1;
    end
  end

  // Store entry payload
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mac_q[widx_i]  <= mac_i;
      addr_q[widx_i] <= waddr_i;
    end
  end

  // Lowest-numbered match and free entry
  always_comb begin
    look_o = '0;
    for (int i = LeaseEntries - 1; i >= 0; i--) begin
      if (valid_q[i] && mac_q[i] == mac_i) begin
        look_o.own_hit  = 1'b1;
        look_o.own_idx  = LeaseIdxW'(i);
        look_o.own_addr = addr_q[i];
      end
      if (valid_q[i] && addr_q[i] == addr_i) begin
        look_o.addr_hit = 1'b1;
        look_o.addr_idx = LeaseIdxW'(i);
      end
      if (!valid_q[i]) begin
        look_o.free_any = 1'b1;
        look_o.free_idx = LeaseIdxW'(i);
      end
    end
  end

endmodule

// File: sv/dla_hash_div.sv
module dla_hash_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] mac_i,
  input  logic [16:0] size_i,
  output logic        done_o,
  output logic [15:0] off_o
);
  import dla_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHash = 2'd1;
  localparam logic [1:0] PhDiv  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [47:0] mac_q, mac_d;
  logic [31:0] h_q, h_d;
  logic [16:0] rem_q, rem_d;
  logic [31:0] mix;
  logic [17:0] trial;
  logic        done_q;

  assign mix   = h_q ^ {24'd0, mac_q[47:40]};
  assign trial = {rem_q, h_q[31]};

  // Hash one byte a cycle, then one remainder bit a cycle
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    mac_d   = mac_q;
    h_d     = h_q;
    rem_d   = rem_q;
    unique case (phase_q)
      PhIdle: begin
        if (start_i) begin
          phase_d = PhHash;
          cnt_d   = '0;
          mac_d   = mac_i;
          h_d     = FnvBasis;
        end
      end
      PhHash: begin
        h_d   = mix * FnvPrime;
        mac_d = {mac_q[39:0], 8'd0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd5) begin
          phase_d = PhDiv;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end
      PhDiv: begin
        h_d = {h_q[30:0], 1'b0};
        if (trial >= {1'b0, size_i}) rem_d = 17'(trial - {1'b0, size_i});
        else rem_d = trial[16:0];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          phase_d = PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  // Flag completion in the cycle after the last remainder step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= (phase_q == PhDiv) && (cnt_q == 5'd31);
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q <= mac_d;
    h_q   <= h_d;
    rem_q <= rem_d;
  end

  assign off_o  = rem_q[15:0];
  assign done_o = done_q;

endmodule

// File: sv/dhcp_lease_allocator_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  in_data_i   (dla_in_t)
// out       output     out_valid_o / out_ready_i out_data_o (dla_out_t)
// cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// With no hashing needed, a message goes via StBnd1, StBnd2, StDecide and StResp
// to the output register; to allocate a new address, the shared hash/modulo unit
// first runs 6 hash steps and 32 remainder steps, then StProbe tries candidates.
// in_ready_o is high only while the sequencer is idle. A finished
// result waits in the output register; the next message may be taken meanwhile,
// and a further result stalls until the waiting one is transferred.
// Reset clears the lease table valid bits and loads the default registers.
module dhcp_lease_allocator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dla_pkg::dla_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dla_pkg::dla_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i
);
  import dla_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StBnd1   = 3'd1;
  localparam logic [2:0] StBnd2   = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StHash   = 3'd4;
  localparam logic [2:0] StProbe  = 3'd5;
  localparam logic [2:0] StResp   = 3'd6;

  // Configuration registers
  logic [31:0] srv_q, mask_q, psh_q;
  logic [15:0] plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_q  <= 32'hC0A80101;
      mask_q <= 32'hFFFFFF00;
      psh_q  <= 32'd100;
      plen_q <= 16'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegServerAddr: srv_q  <= cfg_wdata_i;
        RegSubnetMask: mask_q <= cfg_wdata_i;
        RegPoolStart:  psh_q  <= cfg_wdata_i;
        RegPoolLength: plen_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic [2:0]  state_q, state_d;
  dla_in_t     item_q;
  logic [31:0] want_q, want_d;
  logic        is_req_q, is_req_d;
  logic [31:0] lo_q, lo_d, last_q, last_d, hi_q, hi_d;
  logic        empty_q, empty_d;
  logic [16:0] size_q, size_d, cnt_q, cnt_d;
  logic [15:0] idx_q, idx_d;
  dla_out_t    res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;

  dla_look_t             look;
  logic                  tbl_we;
  logic [LeaseIdxW-1:0]  tbl_widx;
  logic [31:0]           tbl_waddr, query;
  logic                  hd_start, hd_done;
  logic [15:0]           hd_off;

  // Pool bounds arithmetic
  logic [31:0] span, net, first, s_raw, room, cand;
  logic [15:0] nm1;
  logic        over, s_ok;

  assign span  = ~mask_q;
  assign net   = srv_q & mask_q;
  assign first = net + 32'd1;
  assign s_raw = net | (psh_q & span);
  assign s_ok  = (s_raw >= first) && (s_raw <= ((net | span) - 32'd1));
  assign nm1   = (plen_q == 16'd0) ? 16'd0 : plen_q - 16'd1;
  assign room  = last_q - lo_q;
  assign over  = {16'd0, nm1} > room;
  assign cand  = lo_q + {16'd0, idx_q};
  assign query = (state_q == StProbe) ? cand : want_q;

  function automatic logic in_pool(logic [31:0] a, logic e, logic [31:0] l, logic [31:0] h);
    in_pool = !e && (a >= l) && (a <= h);
  endfunction

  dla_lease_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mac_i   (item_q.client_mac),
    .addr_i  (query),
    .we_i    (tbl_we),
    .widx_i  (tbl_widx),
    .waddr_i (tbl_waddr),
    .look_o  (look)
  );

  dla_hash_div u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hd_start),
    .mac_i   (item_q.client_mac),
    .size_i  (size_q),
    .done_o  (hd_done),
    .off_o   (hd_off)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    want_d      = want_q;
    is_req_d    = is_req_q;
    lo_d        = lo_q;
    last_d      = last_q;
    hi_d        = hi_q;
    empty_d     = empty_q;
    size_d      = size_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    tbl_we      = 1'b0;
    tbl_widx    = look.own_hit ? look.own_idx : look.free_idx;
    tbl_waddr   = query;
    hd_start    = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          want_d   = in_data_i.req_addr_valid ? in_data_i.req_addr
                                              : in_data_i.client_cur_addr;
          is_req_d = (in_data_i.req_type == MsgRequest);
          state_d  = StBnd1;
        end
      end
      StBnd1: begin
        empty_d = (span[31:1] == 31'd0);
        last_d  = (net | span) - 32'd1;
        lo_d    = s_ok ? s_raw : first;
        state_d = StBnd2;
      end
      StBnd2: begin
        hi_d    = over ? last_q : lo_q + {16'd0, nm1};
        size_d  = over ? room[16:0] + 17'd1 : {1'b0, nm1} + 17'd1;
        state_d = StDecide;
      end
      StDecide: begin
        res_d   = '{reply_kind: RkNone, assigned_addr: 32'd0, nak_reason: NrNone};
        state_d = StResp;
        if (item_q.req_type == MsgDiscover ||
            (is_req_q && !(item_q.server_id_valid && item_q.server_id != srv_q) &&
             want_q == 32'd0)) begin
          // Allocation route
          if (look.own_hit && in_pool(look.own_addr, empty_q, lo_q, hi_q)) begin
            res_d.reply_kind    = is_req_q ? RkAck : RkOffer;
            res_d.assigned_addr = look.own_addr;
          end else if ((!look.own_hit && !look.free_any) || empty_q) begin
            if (is_req_q) begin
              res_d.reply_kind = RkNak;
              res_d.nak_reason = NrExhausted;
            end
          end else begin
            hd_start = 1'b1;
            state_d  = StHash;
          end
        end else if (is_req_q && !(item_q.server_id_valid && item_q.server_id != srv_q)) begin
          // Check a named address
          res_d.reply_kind = RkNak;
          if ((want_q & mask_q) != net) begin
            res_d.nak_reason = NrSubnet;
          end else if (!in_pool(want_q, empty_q, lo_q, hi_q)) begin
            res_d.nak_reason = NrOutside;
          end else if ((look.addr_hit && (!look.own_hit || look.addr_idx != look.own_idx)) ||
                       (!look.own_hit && !look.free_any)) begin
            res_d.nak_reason = NrInUse;
          end else begin
            tbl_we              = 1'b1;
            res_d.reply_kind    = RkAck;
            res_d.assigned_addr = want_q;
          end
        end
      end
      StHash: begin
        if (hd_done) begin
          idx_d   = hd_off;
          cnt_d   = '0;
          state_d = StProbe;
        end
      end
      StProbe: begin
        if (cnt_q == size_q) begin
          if (is_req_q) begin
            res_d.reply_kind = RkNak;
            res_d.nak_reason = NrExhausted;
          end
          state_d = StResp;
        end else if (cand == srv_q || look.addr_hit) begin
          // Skip and advance
          cnt_d = cnt_q + 17'd1;
          idx_d = ({1'b0, idx_q} + 17'd1 == size_q) ? 16'd0 : idx_q + 16'd1;
        end else begin
          tbl_we              = 1'b1;
          res_d.reply_kind    = is_req_q ? RkAck : RkOffer;
          res_d.assigned_addr = cand;
          state_d             = StResp;
        end
      end
      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold item and working values
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) item_q <= in_data_i;
    want_q   <= want_d;
    is_req_q <= is_req_d;
    lo_q     <= lo_d;
    last_q   <= last_d;
    hi_q     <= hi_d;
    empty_q  <= empty_d;
    size_q   <= size_d;
    cnt_q    <= cnt_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: dv/dhcp_lease_allocator_unit_tb.sv
`timescale 1ns / 1ps

module dhcp_lease_allocator_unit_tb;
  import dla_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  dla_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  dla_out_t    out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  // Shadow copy of the registers and the lease table
  logic [31:0] m_server;
  logic [31:0] m_mask;
  logic [31:0] m_start;
  logic [15:0] m_len;
  logic        tbl_valid [LeaseEntries];
  logic [47:0] tbl_mac   [LeaseEntries];
  logic [31:0] tbl_addr  [LeaseEntries];

  dla_out_t    reply_q[$];
  int          n_fail;
  logic        stall_mode;
  logic [47:0] mac_set [8];

  dhcp_lease_allocator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Pool bounds from the current registers
  function automatic logic pool_range(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] span, net, first, last, s, n;
    span = ~m_mask;
    net  = m_server & m_mask;
    lo = '0;
    hi = '0;
    if (span <= 32'd1) return 1'b0;
    first = net + 32'd1;
    last  = net + span - 32'd1;
    s = net | (m_start & span);
    if (s < first || s > last) s = first;
    n = (m_len != 16'd0) ? {16'd0, m_len} : 32'd1;
    lo = s;
    hi = (n - 32'd1 > last - s) ? last : s + n - 32'd1;
    return 1'b1;
  endfunction

  function automatic logic addr_in_pool(logic [31:0] a);
    logic [31:0] lo, hi;
    if (!pool_range(lo, hi)) return 1'b0;
    return a >= lo && a <= hi;
  endfunction

  function automatic int find_mac(logic [47:0] mac);
    for (int i = 0; i < LeaseEntries; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic int find_addr(logic [31:0] a);
    for (int i = 0; i < LeaseEntries; i++)
      if (tbl_valid[i] && tbl_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < LeaseEntries; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  function automatic logic [31:0] mac_hash(logic [47:0] mac);
    logic [31:0] h;
    h = FnvBasis;
    for (int i = 5; i >= 0; i--) begin
      h = h ^ {24'd0, mac[8*i +: 8]};
      h = h * FnvPrime;
    end
    return h;
  endfunction

  function automatic logic bind_lease(logic [47:0] mac, logic [31:0] a);
    int own, holder;
    own = find_mac(mac);
    holder = find_addr(a);
    if (holder >= 0 && holder != own) return 1'b0;
    if (own < 0) own = find_free();
    if (own < 0) return 1'b0;
    tbl_valid[own] = 1'b1;
    tbl_mac[own]   = mac;
    tbl_addr[own]  = a;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_addr(logic [47:0] mac);
    int own;
    logic [31:0] lo, hi, sz, off, cand;
    own = find_mac(mac);
    if (own >= 0 && addr_in_pool(tbl_addr[own])) return tbl_addr[own];
    if (own < 0 && find_free() < 0) return '0;
    if (!pool_range(lo, hi)) return '0;
    sz  = hi - lo + 32'd1;
    off = mac_hash(mac) % sz;
    for (logic [32:0] i = 0; i < sz; i++) begin
      cand = lo + 32'(({1'b0, off} + i) % {1'b0, sz});
      if (cand == m_server || find_addr(cand) >= 0) continue;
      if (bind_lease(mac, cand)) return cand;
      break;
    end
    return '0;
  endfunction

  // Work out the server's answer and update the shadow table
  function automatic dla_out_t predict_reply(dla_in_t m);
    dla_out_t r;
    logic [31:0] want;
    r = '0;
    if (m.req_type == MsgDiscover) begin
      r.assigned_addr = pick_addr(m.client_mac);
      if (r.assigned_addr != '0) r.reply_kind = RkOffer;
    end else if (m.req_type == MsgRequest &&
                 !(m.server_id_valid && m.server_id != m_server)) begin
      want = m.req_addr_valid ? m.req_addr : m.client_cur_addr;
      if (want == '0) begin
        r.assigned_addr = pick_addr(m.client_mac);
        if (r.assigned_addr != '0) r.reply_kind = RkAck;
        else begin
          r.reply_kind = RkNak;
          r.nak_reason = NrExhausted;
        end
      end else if ((want & m_mask) != (m_server & m_mask)) begin
        r.reply_kind = RkNak;
        r.nak_reason = NrSubnet;
      end else if (!addr_in_pool(want)) begin
        r.reply_kind = RkNak;
        r.nak_reason = NrOutside;
      end else if (!bind_lease(m.client_mac, want)) begin
        r.reply_kind = RkNak;
        r.nak_reason = NrInUse;
      end else begin
        r.reply_kind = RkAck;
        r.assigned_addr = want;
      end
    end
    return r;
  endfunction

  // Send one message, predicting its reply at the transfer
  task automatic send_msg(dla_in_t m);
    dla_out_t exp_r;
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_r = predict_reply(m);
    reply_q.push_back(exp_r);
  endtask

  // Drop valid and wait for every reply
  task automatic drain();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      RegServerAddr: m_server = val;
      RegSubnetMask: m_mask   = val;
      RegPoolStart:  m_start  = val;
      default:       m_len    = val[15:0];
    endcase
  endtask

  task automatic set_pool(logic [31:0] srv, logic [31:0] msk, logic [31:0] st,
                          logic [15:0] len);
    drain();
    write_reg(RegServerAddr, srv);
    write_reg(RegSubnetMask, msk);
    write_reg(RegPoolStart, st);
    write_reg(RegPoolLength, {16'd0, len});
    cfg_we_i <= 1'b0;
  endtask

  function automatic dla_in_t make_msg(logic [7:0] t, logic [47:0] mac, logic rav,
                                       logic [31:0] ra, logic [31:0] ci, logic sv,
                                       logic [31:0] sid);
    dla_in_t m;
    m.req_type = t;
    m.client_mac = mac;
    m.req_addr_valid = rav;
    m.req_addr = ra;
    m.client_cur_addr = ci;
    m.server_id_valid = sv;
    m.server_id = sid;
    return m;
  endfunction

  // Zero, or an address near the pool, in the subnet, or anywhere
  function automatic logic [31:0] rand_addr();
    logic [31:0] lo, hi;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom();
      2: return (m_server & m_mask) | ($urandom() & ~m_mask);
      default: begin
        if (!pool_range(lo, hi)) return m_server;
        return lo + $urandom_range(0, 9) - 2;
      end
    endcase
  endfunction

  function automatic dla_in_t rand_msg();
    logic [7:0] t;
    logic [47:0] mac;
    case ($urandom_range(0, 9))
      0:       t = 8'($urandom());
      1, 2, 3: t = MsgDiscover;
      default: t = MsgRequest;
    endcase
    mac = ($urandom_range(0, 4) == 0) ? {16'($urandom()), 32'($urandom())}
                                      : mac_set[$urandom_range(0, 7)];
    return make_msg(t, mac, 1'($urandom()), rand_addr(), rand_addr(),
                    $urandom_range(0, 3) == 0,
                    ($urandom_range(0, 3) == 0) ? 32'($urandom()) : m_server);
  endfunction

  task automatic test_directed();
    logic [31:0] a;
    send_msg(make_msg(8'd0, '0, 1'b0, '0, '0, 1'b0, '0));
    send_msg(make_msg(8'hFF, '1, 1'b1, '1, '1, 1'b1, '1));
    send_msg(make_msg(MsgDiscover, '0, 1'b0, '0, '0, 1'b0, '0));
    send_msg(make_msg(MsgDiscover, '1, 1'b1, '1, '1, 1'b1, '1));
    send_msg(make_msg(MsgRequest, '1, 1'b0, '0, '0, 1'b1, m_server));
    // wrong server id, bad subnet, outside pool, good ack, in use
    send_msg(make_msg(MsgRequest, 48'h1, 1'b1, 32'hC0A80170, '0, 1'b1, 32'h1));
    send_msg(make_msg(MsgRequest, 48'h1, 1'b1, 32'h0A000001, '0, 1'b0, '0));
    send_msg(make_msg(MsgRequest, 48'h1, 1'b0, '0, 32'hC0A801FE, 1'b0, '0));
    send_msg(make_msg(MsgRequest, 48'h2, 1'b1, 32'hC0A80170, '0, 1'b0, '0));
    send_msg(make_msg(MsgRequest, 48'h3, 1'b1, 32'hC0A80170, '0, 1'b0, '0));
    // fill the table with discovers, then requests from further clients
    for (int i = 0; i < 9; i++)
      send_msg(make_msg(MsgDiscover, 48'hA0 + i, 1'b0, '0, '0, 1'b0, '0));
    send_msg(make_msg(MsgRequest, 48'hBB, 1'b1, 32'hC0A80190, '0, 1'b0, '0));
    send_msg(make_msg(MsgRequest, 48'hBC, 1'b0, '0, '0, 1'b0, '0));
  endtask

  // Edge pools: one address shared with the server (every probe skipped), then empty pools
  task automatic test_edge_pools();
    set_pool(32'hC0A80101, 32'hFFFFFF00, 32'd1, 16'd0);
    send_msg(make_msg(MsgDiscover, 48'h5, 1'b0, '0, '0, 1'b0, '0));
    send_msg(make_msg(MsgRequest, 48'h5, 1'b0, '0, '0, 1'b0, '0));
    set_pool(32'h0A000000, 32'hFFFFFFFE, 32'hFFFFFFFF, 16'hFFFF);
    send_msg(make_msg(MsgDiscover, 48'h6, 1'b0, '0, '0, 1'b0, '0));
    send_msg(make_msg(MsgRequest, 48'h6, 1'b0, '0, '0, 1'b0, '0));
    set_pool(32'hFFFFFFFF, 32'hFFFFFFFF, '0, 16'd1);
    send_msg(make_msg(MsgRequest, 48'h6, 1'b1, 32'hFFFFFFFF, '0, 1'b0, '0));
    // existing leases move when the pool shifts
    set_pool(32'hC0A80101, 32'hFFFFFF00, 32'd200, 16'd4);
    for (int i = 0; i < 4; i++)
      send_msg(make_msg(MsgDiscover, 48'hA0 + i, 1'b0, '0, '0, 1'b0, '0));
    set_pool('0, '0, 32'hFFFFFFFF, 16'hFFFF);
    send_msg(make_msg(MsgDiscover, 48'hA1, 1'b0, '0, '0, 1'b0, '0));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 4))
          0: set_pool(32'hC0A80101, 32'hFFFFFF00, 32'd100, 16'd50);
          1: set_pool($urandom(), 32'hFFFFFFF0, $urandom(), 16'($urandom_range(0, 20)));
          2: set_pool($urandom(), 32'hFFFFFC00, $urandom(), 16'($urandom()));
          3: set_pool($urandom(), ~(32'hF << $urandom_range(0, 3)), $urandom(),
                      16'($urandom_range(0, 6)));
          default: set_pool($urandom(), $urandom(), $urandom(), 16'($urandom()));
        endcase
        for (int k = 0; k < 8; k++) mac_set[k] = {16'($urandom()), 32'($urandom())};
      end
      send_msg(rand_msg());
    end
  endtask

  // Check each reply against the oldest expectation
  always @(posedge clk_i) begin
    dla_out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        $error("unexpected reply %p", out_data_o);
        n_fail++;
      end else begin
        exp_r = reply_q.pop_front();
        if (out_data_o.reply_kind !== exp_r.reply_kind) begin
          $error("reply_kind exp %0d got %0d", exp_r.reply_kind, out_data_o.reply_kind);
          n_fail++;
        end
        if (out_data_o.assigned_addr !== exp_r.assigned_addr) begin
          $error("assigned_addr exp %h got %h", exp_r.assigned_addr,
                 out_data_o.assigned_addr);
          n_fail++;
        end
        if (out_data_o.nak_reason !== exp_r.nak_reason) begin
          $error("nak_reason exp %0d got %0d", exp_r.nak_reason, out_data_o.nak_reason);
          n_fail++;
        end
      end
    end
  end

  // Receiver stall pattern: calm and busy stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_ready_i <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  initial begin
    #20_000_000;
    $display("** dhcp_lease_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    n_fail = 0;
    stall_mode = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegServerAddr;
    cfg_wdata_i = '0;
    m_server = 32'hC0A80101;
    m_mask = 32'hFFFFFF00;
    m_start = 32'd100;
    m_len = 16'd50;
    for (int i = 0; i < LeaseEntries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i] = '0;
      tbl_addr[i] = '0;
    end
    for (int k = 0; k < 8; k++) mac_set[k] = {16'($urandom()), 32'($urandom())};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_edge_pools();
    test_random(1650);
    drain();
    if (n_fail == 0) $display("** dhcp_lease_allocator_unit: PASSED **");
    else $display("** dhcp_lease_allocator_unit: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
sv/dla_pkg.sv
sv/dla_lease_table.sv
sv/dla_hash_div.sv
sv/dhcp_lease_allocator_unit.sv
dv/dhcp_lease_allocator_unit_tb.sv
